// ===== hdl/decimal_price_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Decimal price parser assertion macros
// Concurrent check macros used by the top file of the parser core.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_PRICE_PARSER_CORE_ASSERT_SVH
`define DECIMAL_PRICE_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPP_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal price parser package
// Status codes, character codes and the power-of-ten table.
// ----------------------------------------------------------------------------
package dpp_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_EXTRA_DEC = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // ASCII characters of interest.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // The integer part never exceeds 2^63-1, so it fits in 63 bits.
  localparam int WHOLE_W = 63;
  // Width of the largest power of ten in the table (10^8).
  localparam int POW_W = 27;

  typedef logic [POW_W-1:0] pow_t;

  // Powers of ten from 10^0 up to 10^8.
  function automatic pow_t pow10_lut(input logic [3:0] n);
    pow_t p;
    case (n)
      4'd0:    p = POW_W'(1);
      4'd1:    p = POW_W'(10);
      4'd2:    p = POW_W'(100);
      4'd3:    p = POW_W'(1000);
      4'd4:    p = POW_W'(10000);
      4'd5:    p = POW_W'(100000);
      4'd6:    p = POW_W'(1000000);
      4'd7:    p = POW_W'(10000000);
      4'd8:    p = POW_W'(100000000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/dpp_front.sv =====
// ----------------------------------------------------------------------------
// Decimal price parser front end
// Classifies each character and accumulates integer and fraction digits.
// ----------------------------------------------------------------------------
module dpp_front import dpp_pkg::*; #(
  parameter int NUM_DECIMALS = 4,
  localparam int FRAC_W = $clog2(10**NUM_DECIMALS),
  localparam int CNT_W  = $clog2(NUM_DECIMALS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // Character channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_code,
  input  logic                 char_present,
  input  logic                 last_char,
  // Finished string towards the queue.
  output logic                 push,
  input  logic                 push_ready,
  output logic [1:0]           push_status,
  output logic                 push_neg,
  output logic [WHOLE_W-1:0]   push_whole,
  output logic [FRAC_W-1:0]    push_frac,
  output logic [CNT_W-1:0]     push_count
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_INT   = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;

  logic [1:0]         phase, phase_next;
  logic               is_negative, is_negative_next;
  logic               seen_digit, seen_digit_next;
  logic [WHOLE_W-1:0] whole_part, whole_part_next;
  logic [FRAC_W-1:0]  fraction_part, fraction_part_next;
  logic [CNT_W-1:0]   fraction_count, fraction_count_next;
  logic [1:0]         error_code, error_code_next;

  logic               accept;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic               halted;
  logic [WHOLE_W+3:0] whole_grown;
  logic [FRAC_W+3:0]  frac_grown;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit_val = is_digit ? char_code[3:0] : 4'd0;
  assign halted    = (error_code == ST_MALFORMED) || (error_code == ST_EXTRA_DEC);

  // Multiply-by-ten accumulate as shift and add.
  assign whole_grown = ({4'b0, whole_part} << 3) + ({4'b0, whole_part} << 1)
                     + (WHOLE_W+4)'(digit_val);
  assign frac_grown  = ({4'b0, fraction_part} << 3) + ({4'b0, fraction_part} << 1)
                     + (FRAC_W+4)'(digit_val);

  // Next state for one character.
  always_comb begin
    phase_next          = phase;
    is_negative_next    = is_negative;
    seen_digit_next     = seen_digit;
    whole_part_next     = whole_part;
    fraction_part_next  = fraction_part;
    fraction_count_next = fraction_count;
    error_code_next     = error_code;
    if (char_present && !halted) begin
      if (phase == PH_START && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
        is_negative_next = (char_code == CH_MINUS);
        phase_next       = PH_INT;
      end else if (phase != PH_FRAC && char_code == CH_POINT) begin
        phase_next = PH_FRAC;
      end else if (is_digit && phase != PH_FRAC) begin
        phase_next      = PH_INT;
        seen_digit_next = 1'b1;
        if (error_code != ST_OVERFLOW) begin
          if (whole_grown[WHOLE_W+3:WHOLE_W] != 4'd0) begin
            error_code_next = ST_OVERFLOW;
          end else begin
            whole_part_next = whole_grown[WHOLE_W-1:0];
          end
        end
      end else if (is_digit) begin
        seen_digit_next = 1'b1;
        if (fraction_count < CNT_W'(NUM_DECIMALS)) begin
          fraction_part_next  = frac_grown[FRAC_W-1:0];
          fraction_count_next = fraction_count + CNT_W'(1);
        end else if (digit_val != 4'd0) begin
          error_code_next = ST_EXTRA_DEC;
        end
      end else begin
        error_code_next = ST_MALFORMED;
      end
    end
  end

  // Hand the finished string to the queue on the last character.
  assign push        = accept && last_char;
  assign push_status = (error_code_next == ST_OK && !seen_digit_next) ? ST_MALFORMED
                                                                      : error_code_next;
  assign push_neg    = is_negative_next;
  assign push_whole  = whole_part_next;
  assign push_frac   = fraction_part_next;
  assign push_count  = fraction_count_next;

  // State update; a finished string clears everything.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase          <= PH_START;
      is_negative    <= 1'b0;
      seen_digit     <= 1'b0;
      whole_part     <= '0;
      fraction_part  <= '0;
      fraction_count <= '0;
      error_code     <= ST_OK;
    end else if (accept) begin
      phase          <= phase_next;
      is_negative    <= is_negative_next;
      seen_digit     <= seen_digit_next;
      whole_part     <= whole_part_next;
      fraction_part  <= fraction_part_next;
      fraction_count <= fraction_count_next;
      error_code     <= error_code_next;
    end
  end

endmodule

// ===== hdl/dpp_queue.sv =====
// ----------------------------------------------------------------------------
// Decimal price parser queue
// Two-entry queue between the front end and the scaling back end.
// ----------------------------------------------------------------------------
module dpp_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic [1:0]        count;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] tail;
  logic              wr_fire;
  logic              rd_fire;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = head;
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (wr_fire && !rd_fire) begin
      count <= count + 2'd1;
    end else if (rd_fire && !wr_fire) begin
      count <= count - 2'd1;
    end
  end

  // Entry storage; the head is always the oldest transaction.
  always_ff @(posedge clk) begin
    if (wr_fire && rd_fire) begin
      if (count == 2'd1) begin
        head <= wr_data;
      end else begin
        head <= tail;
        tail <= wr_data;
      end
    end else if (rd_fire) begin
      head <= tail;
    end else if (wr_fire) begin
      if (count == 2'd0) begin
        head <= wr_data;
      end else begin
        tail <= wr_data;
      end
    end
  end

endmodule

// ===== hdl/dpp_back.sv =====
// ----------------------------------------------------------------------------
// Decimal price parser back end
// Scales the digits by the decimal base, checks range and applies the sign.
// ----------------------------------------------------------------------------
module dpp_back import dpp_pkg::*; #(
  parameter int NUM_DECIMALS = 4,
  localparam int FRAC_W = $clog2(10**NUM_DECIMALS),
  localparam int CNT_W  = $clog2(NUM_DECIMALS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_status,
  input  logic               in_neg,
  input  logic [WHOLE_W-1:0] in_whole,
  input  logic [FRAC_W-1:0]  in_frac,
  input  logic [CNT_W-1:0]   in_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] price
);

  localparam int HI_W  = WHOLE_W - 32;
  localparam int SUM_W = WHOLE_W + FRAC_W + 1;
  localparam logic [FRAC_W-1:0] SCALE = FRAC_W'(10**NUM_DECIMALS);

  // Stage one: partial products.
  logic                   v1;
  logic [1:0]             status1;
  logic                   neg1;
  logic [32+FRAC_W-1:0]   prod_lo;
  logic [HI_W+FRAC_W-1:0] prod_hi;
  logic [FRAC_W-1:0]      frac1;
  // Stage two: magnitude and range check.
  logic                   v2;
  logic [1:0]             status2;
  logic                   neg2;
  logic [WHOLE_W-1:0]     mag2;

  logic                   rdy1, rdy2, rdy3;
  logic [FRAC_W+POW_W-1:0] frac_scaled;
  logic [SUM_W-1:0]       sum;
  logic [WHOLE_W:0]       mag_ext;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Pad the fraction to the full number of decimals.
  assign frac_scaled = FRAC_W'(in_frac) * pow10_lut(4'(NUM_DECIMALS) - 4'(in_count));

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  // Stage one registers: the integer part times the scale in two halves.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      status1 <= in_status;
      neg1    <= in_neg;
      prod_lo <= in_whole[31:0] * SCALE;
      prod_hi <= in_whole[WHOLE_W-1:32] * SCALE;
      frac1   <= frac_scaled[FRAC_W-1:0];
    end
  end

  // Stage two: combine partial products and test against 2^63-1.
  assign sum = (SUM_W'(prod_hi) << 32) + SUM_W'(prod_lo) + SUM_W'(frac1);

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      neg2 <= neg1;
      mag2 <= sum[WHOLE_W-1:0];
      if (status1 == ST_OK && sum[SUM_W-1:WHOLE_W] != '0) begin
        status2 <= ST_OVERFLOW;
      end else begin
        status2 <= status1;
      end
    end
  end

  // Output register: sign applied, price forced to zero on any error.
  assign mag_ext = {1'b0, mag2};

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      status <= status2;
      if (status2 != ST_OK) begin
        price <= '0;
      end else if (neg2) begin
        price <= -$signed(mag_ext);
      end else begin
        price <= $signed(mag_ext);
      end
    end
  end

endmodule

// ===== hdl/decimal_price_parser_core.sv =====
// ----------------------------------------------------------------------------
// Decimal price parser core
// Parses a decimal price string, one character per transaction, into a
// signed fixed-point value scaled by ten to the number of decimals.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | char_code, char_present, last_char
//  out     | output    | out_valid / out_ready | status, price
//
//  One character is taken every cycle while the two-entry queue has room.
//  After its last character is accepted, a result passes in order through
//  the queue entry, the partial-product stage, the range-check stage and
//  the signed output register before it is presented.
//  Reset is synchronous and clears the parse state, the queue and all valids.
//  A stalled output fills the back end and then the queue; once the queue
//  holds two finished strings, no character is accepted until an entry leaves.
// ----------------------------------------------------------------------------
`include "decimal_price_parser_core_assert.svh"

module decimal_price_parser_core import dpp_pkg::*; #(
  parameter int NUM_DECIMALS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               char_present,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] price
);

  localparam int FRAC_W = $clog2(10**NUM_DECIMALS);
  localparam int CNT_W  = $clog2(NUM_DECIMALS + 1);
  localparam int Q_W    = 2 + 1 + WHOLE_W + FRAC_W + CNT_W;

  logic               push, push_ready;
  logic [1:0]         push_status;
  logic               push_neg;
  logic [WHOLE_W-1:0] push_whole;
  logic [FRAC_W-1:0]  push_frac;
  logic [CNT_W-1:0]   push_count;

  logic               q_valid, q_ready;
  logic [Q_W-1:0]     q_data;
  logic [1:0]         q_status;
  logic               q_neg;
  logic [WHOLE_W-1:0] q_whole;
  logic [FRAC_W-1:0]  q_frac;
  logic [CNT_W-1:0]   q_count;

  // Character classification and digit accumulation.
  dpp_front #(.NUM_DECIMALS(NUM_DECIMALS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .char_present (char_present),
    .last_char    (last_char),
    .push         (push),
    .push_ready   (push_ready),
    .push_status  (push_status),
    .push_neg     (push_neg),
    .push_whole   (push_whole),
    .push_frac    (push_frac),
    .push_count   (push_count)
  );

  // Queue of finished strings.
  dpp_queue #(.DATA_W(Q_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  ({push_status, push_neg, push_whole, push_frac, push_count}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign {q_status, q_neg, q_whole, q_frac, q_count} = q_data;

  // Scaling, range check and sign.
  dpp_back #(.NUM_DECIMALS(NUM_DECIMALS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_status (q_status),
    .in_neg    (q_neg),
    .in_whole  (q_whole),
    .in_frac   (q_frac),
    .in_count  (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .price     (price)
  );

  // An error result always carries a zero price.
  `DPP_ASSERT_SAME(a_err_zero_price, clk, rst, out_valid && status != ST_OK, price == '0)
  // The most negative value is never produced; it is reported as overflow.
  `DPP_ASSERT_SAME(a_no_min_price, clk, rst, out_valid, price != {1'b1, 63'b0})
  // A finished string is held in the queue in the cycle after it ends.
  `DPP_ASSERT_NEXT(a_last_queued, clk, rst, in_valid && in_ready && last_char, q_valid)

endmodule
